// ===== rtl/sorted_table_binary_search_unit_defines.svh =====
// assertion macros shared by the sorted table search unit
`ifndef SORTED_TABLE_BINARY_SEARCH_UNIT_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define STBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("stbs: assertion failed");

// next-cycle implication, disabled while in reset
`define STBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("stbs: assertion failed");

`endif

// ===== rtl/stbs_pkg.sv =====
// shared types and constants of the sorted table search unit
package stbs_pkg;

	localparam int DEPTH_DEF = 16;

	localparam int ENTRY_W = 32;
	localparam int IDX_W   = 4;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// item kinds
	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	// register index on the configuration port
	localparam logic [0:0] REG_RANGE_END = 1'b0;

	localparam logic [IDX_W-1:0] RANGE_END_RST = 4'd15;

	// controller to datapath commands
	typedef struct packed {
		logic wr;
		logic load;
		logic step;
	} stbs_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic hit;
		logic stop;
	} stbs_stat_t;

endpackage

// ===== rtl/sorted_table_binary_search_unit.sv =====
// top level of the sorted table binary search unit
// A write item (kind 0) stores its value at entry_index and gives no result. A search item
// (kind 1) runs p probes, where p is at most floor(log2(n))+1 for n entries in the search
// range (five for a 16-entry range), and no new start is taken until the probes are done;
// done pulses for one cycle with found and index at the end of the last probe. The probe
// loop does one registered table read and one signed compare per cycle. done cannot be
// held off, so the result must be taken in the cycle it is shown; busy stays high only
// while probes are running.
module sorted_table_binary_search_unit #(
	parameter int DEPTH = stbs_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                kind,
	input  logic [stbs_pkg::IDX_W-1:0]          entry_index,
	input  logic signed [stbs_pkg::ENTRY_W-1:0] value,
	output logic                                done,
	output logic                                found,
	output logic [stbs_pkg::IDX_W-1:0]          index,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [stbs_pkg::PADDR_W-1:0]        paddr,
	input  logic [stbs_pkg::PDATA_W-1:0]        pwdata,
	output logic [stbs_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready
);
	import stbs_pkg::*;

	stbs_cmd_t        cmd;
	stbs_stat_t       stat;
	logic [IDX_W-1:0] range_end;

	stbs_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.range_end (range_end)
	);

	stbs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	stbs_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk         (clk),
		.cmd         (cmd),
		.stat        (stat),
		.entry_index (entry_index),
		.value       (value),
		.range_end   (range_end),
		.found       (found),
		.index       (index)
	);

endmodule

// ===== rtl/stbs_regs.sv =====
// configuration register file on the apb-style port
module stbs_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [stbs_pkg::PADDR_W-1:0] paddr,
	input  logic [stbs_pkg::PDATA_W-1:0] pwdata,
	output logic [stbs_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output logic [stbs_pkg::IDX_W-1:0]   range_end
);
	import stbs_pkg::*;

	logic [IDX_W-1:0] range_end_q;
	logic [0:0]       reg_idx;
	logic             wr_xfer;

	assign reg_idx = paddr[2];
	assign pready  = 1'b1;
	assign wr_xfer = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_end_q <= RANGE_END_RST;
		end else if (wr_xfer && (reg_idx == REG_RANGE_END)) begin
			range_end_q <= pwdata[IDX_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RANGE_END: prdata = {{(PDATA_W-IDX_W){1'b0}}, range_end_q};
			default:       prdata = '0;
		endcase
	end

	assign range_end = range_end_q;

endmodule

// ===== rtl/stbs_dpath.sv =====
// table memory, search range registers and probe comparator
module stbs_dpath #(
	parameter int DEPTH = stbs_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  stbs_pkg::stbs_cmd_t                cmd,
	output stbs_pkg::stbs_stat_t               stat,
	input  logic [stbs_pkg::IDX_W-1:0]         entry_index,
	input  logic signed [stbs_pkg::ENTRY_W-1:0] value,
	input  logic [stbs_pkg::IDX_W-1:0]         range_end,
	output logic                               found,
	output logic [stbs_pkg::IDX_W-1:0]         index
);
	import stbs_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic signed [ENTRY_W-1:0] mem [DEPTH];

	logic signed [ENTRY_W-1:0] key_q;
	logic signed [ENTRY_W-1:0] rd_data_q;
	logic [IDX_W-1:0]          lo_q;
	logic [IDX_W-1:0]          hi_q;
	logic [IDX_W-1:0]          mid_q;
	logic                      found_q;
	logic [IDX_W-1:0]          index_q;

	logic [IDX_W-1:0] top;
	logic [IDX_W-1:0] lo_n;
	logic [IDX_W-1:0] hi_n;
	logic [IDX_W-1:0] mid_n;
	logic [IDX_W-1:0] rd_addr;
	logic             gt;
	logic             lt;
	logic             wr_ok;

	// search range never runs past the table
	assign top = (32'(range_end) > DEPTH - 1) ? IDX_W'(DEPTH - 1) : range_end;

	assign gt = key_q > rd_data_q;
	assign lt = key_q < rd_data_q;

	assign stat.hit  = !gt && !lt;
	// range empties when the probe sits on the bound it would step past
	assign stat.stop = stat.hit || (gt && (mid_q == hi_q)) || (lt && (mid_q == lo_q));

	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		if (gt) begin
			lo_n = mid_q + 1'b1;
		end else if (lt) begin
			hi_n = mid_q - 1'b1;
		end
		mid_n = IDX_W'(({1'b0, lo_n} + {1'b0, hi_n}) >> 1);
	end

	assign rd_addr = cmd.load ? (top >> 1) : mid_n;
	assign wr_ok   = cmd.wr && (32'(entry_index) < DEPTH);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[AW'(entry_index)] <= value;
		end
		rd_data_q <= mem[AW'(rd_addr)];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= value;
			lo_q  <= '0;
			hi_q  <= top;
			mid_q <= top >> 1;
		end else if (cmd.step && !stat.stop) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n;
		end
		if (cmd.step && stat.stop) begin
			found_q <= stat.hit;
			index_q <= mid_q;
		end
	end

	assign found = found_q;
	assign index = index_q;

endmodule

// ===== rtl/stbs_ctrl.sv =====
// search controller state machine
`include "sorted_table_binary_search_unit_defines.svh"

module stbs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 kind,
	input  stbs_pkg::stbs_stat_t stat,
	output stbs_pkg::stbs_cmd_t  cmd,
	output logic                 busy,
	output logic                 done
);
	import stbs_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_PROBE
	} state_t;

	state_t state_q;
	logic   done_q;
	logic   take;

	assign busy = (state_q != ST_IDLE);
	assign take = start && !busy;

	assign cmd.wr   = take && (kind == KIND_WRITE);
	assign cmd.load = take && (kind == KIND_SEARCH);
	assign cmd.step = (state_q == ST_PROBE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (stat.stop) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done = done_q;

	`STBS_ASSERT_NXT(a_load_probes, clk, arst_n, cmd.load, state_q == ST_PROBE)
	`STBS_ASSERT_NXT(a_stop_done, clk, arst_n, (state_q == ST_PROBE) && stat.stop,
		(state_q == ST_IDLE) && done_q)
	`STBS_ASSERT_IMP(a_done_src, clk, arst_n, done_q, $past(state_q == ST_PROBE))

endmodule
